// ===== hw/rtl/mqsb_pkg.sv =====
package mqsb_pkg;

    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QID_W   = 3;
    localparam int OUT_W   = 32;
    localparam int STAT_W  = 2;

    // operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    // slot pointer with valid flag, null when valid is low
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
    } ptr_t;

    localparam int PTR_W = $bits(ptr_t);

    // request bundle towards the link store
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        ptr_t              wdata;
    } link_req_t;

endpackage

// ===== hw/rtl/mqsb_ram.sv =====
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mqsb_link_store.sv =====
module mqsb_link_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mqsb_pkg::link_req_t   req,
    output mqsb_pkg::ptr_t        rdata
);
    import mqsb_pkg::*;

    logic [PTR_W-1:0]  ram_rdata;
    logic [SLOTS-1:0]  written_reg;
    logic              written_hold_reg;
    logic [SLOT_W-1:0] raddr_hold_reg;
    ptr_t              dflt;

    mqsb_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as the chained reset pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg      <= '0;
            written_hold_reg <= 1'b0;
            raddr_hold_reg   <= '0;
        end
        else
        begin
            if (req.we)
            begin
                written_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                written_hold_reg <= written_reg[req.raddr];
                raddr_hold_reg   <= req.raddr;
            end
        end
    end

    always_comb
    begin
        dflt.idx   = SLOT_W'(raddr_hold_reg + 1'b1);
        dflt.valid = (raddr_hold_reg != SLOT_W'(SLOTS - 1));
    end

    assign rdata = written_hold_reg ? ptr_t'(ram_rdata) : dflt;

endmodule

// ===== hw/rtl/multi_queue_shared_buffer_top.sv =====
// channel  | dir | beat fields (lowest bit up)                  | accepted when
// ---------+-----+----------------------------------------------+-------------------
// s_axis   | in  | tuser: mode[0], queue_id[3:1]; tdata: data_in | s_tvalid & s_tready
// m_axis   | out | tdata: data_out[31:0]; tuser: status[1:0]     | m_tvalid & m_tready
//
// one operation at a time: enqueue steps through EXEC, ENQ_B and ENQ_C, dequeue through EXEC
// and DEQ_B, a rejected beat ends in EXEC; the last step loads the result register, and the
// next beat is taken back in IDLE; set by the registered read of the link memory and its
// single write port (enqueue writes the new tail link and, for a non-empty queue, the old one)
// reset: all queues empty, free list chains every slot in order; no clearing pass, unwritten
// links read as the chained pattern through per-slot written flags
// a held result stalls only the final step; the next beat may be taken while it waits
module multi_queue_shared_buffer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_in[31:0]
    input  logic [3:0]  s_tuser,   // mode[0], queue_id[3:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import mqsb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENQ_B,
        ST_ENQ_C,
        ST_DEQ_B
    } state_t;

    state_t                state_reg;
    logic                  mode_reg;
    logic [QIDX_W-1:0]     q_reg;
    logic                  qok_reg;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [SLOT_W-1:0]     slot_reg;
    ptr_t                  free_head_reg;
    ptr_t                  head_reg [QUEUES];
    logic [SLOT_W-1:0]     tail_reg [QUEUES];
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic [STAT_W-1:0]     m_tuser_reg;

    logic                  qid_ok;
    logic                  out_free;
    logic                  enq_ok;
    logic                  deq_ok;
    logic                  result_load;
    link_req_t             link_req;
    ptr_t                  link_rdata;
    logic                  data_we;
    logic                  data_re;
    logic [SLOT_W-1:0]     data_waddr;
    logic [SLOT_W-1:0]     data_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;

    // link memory with reset pattern
    mqsb_link_store u_links (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (link_req),
        .rdata (link_rdata)
    );

    // slot payload memory, no reset
    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (din_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign qid_ok   = (s_tuser[3:1] != '0) &&
                      ({4'd0, s_tuser[3:1]} <= 7'(QUEUES));
    assign out_free = !m_tvalid_reg || m_tready;
    assign enq_ok   = (mode_reg == MODE_ENQ) && qok_reg && free_head_reg.valid;
    assign deq_ok   = (mode_reg == MODE_DEQ) && qok_reg && head_reg[q_reg].valid;

    // final step of an operation loads the result register
    assign result_load = out_free &&
                         (((state_reg == ST_EXEC) && !enq_ok && !deq_ok) ||
                          (state_reg == ST_ENQ_C) || (state_reg == ST_DEQ_B));

    // memory requests per step
    always_comb
    begin
        link_req   = '0;
        data_we    = 1'b0;
        data_re    = 1'b0;
        data_waddr = free_head_reg.idx;
        data_raddr = head_reg[q_reg].idx;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (enq_ok)
                begin
                    // fetch the next free slot, store the payload
                    link_req.re    = 1'b1;
                    link_req.raddr = free_head_reg.idx;
                    data_we        = 1'b1;
                end
                else if (deq_ok)
                begin
                    link_req.re    = 1'b1;
                    link_req.raddr = head_reg[q_reg].idx;
                    data_re        = 1'b1;
                end
            end
            ST_ENQ_B:
            begin
                // new tail links to null
                link_req.we    = 1'b1;
                link_req.waddr = slot_reg;
                link_req.wdata = '0;
            end
            ST_ENQ_C:
            begin
                if (out_free && head_reg[q_reg].valid)
                begin
                    link_req.we          = 1'b1;
                    link_req.waddr       = tail_reg[q_reg];
                    link_req.wdata.valid = 1'b1;
                    link_req.wdata.idx   = slot_reg;
                end
            end
            ST_DEQ_B:
            begin
                if (out_free)
                begin
                    // freed slot goes to the front of the free list
                    link_req.we    = 1'b1;
                    link_req.waddr = slot_reg;
                    link_req.wdata = free_head_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            mode_reg            <= MODE_ENQ;
            q_reg               <= '0;
            qok_reg             <= 1'b0;
            din_reg             <= '0;
            slot_reg            <= '0;
            free_head_reg.valid <= 1'b1;
            free_head_reg.idx   <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            m_tvalid_reg        <= 1'b0;
            m_tdata_reg         <= '0;
            m_tuser_reg         <= STATUS_OK;
        end
        else
        begin
            if (result_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg  <= s_tuser[0];
                        q_reg     <= QIDX_W'(QID_W'(s_tuser[3:1] - 1'b1));
                        qok_reg   <= qid_ok;
                        din_reg   <= s_tdata[DATA_WIDTH-1:0];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (enq_ok)
                    begin
                        slot_reg  <= free_head_reg.idx;
                        state_reg <= ST_ENQ_B;
                    end
                    else if (deq_ok)
                    begin
                        slot_reg  <= head_reg[q_reg].idx;
                        state_reg <= ST_DEQ_B;
                    end
                    else if (out_free)
                    begin
                        // store full, queue empty or queue id out of range, nothing changes
                        m_tdata_reg  <= '1;
                        m_tuser_reg  <= (mode_reg == MODE_DEQ) ? STATUS_EMPTY : STATUS_FULL;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_ENQ_B:
                begin
                    free_head_reg <= link_rdata;
                    state_reg     <= ST_ENQ_C;
                end
                ST_ENQ_C:
                begin
                    if (out_free)
                    begin
                        if (!head_reg[q_reg].valid)
                        begin
                            head_reg[q_reg].valid <= 1'b1;
                            head_reg[q_reg].idx   <= slot_reg;
                        end
                        tail_reg[q_reg] <= slot_reg;
                        m_tdata_reg     <= '1;
                        m_tuser_reg     <= STATUS_OK;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_DEQ_B:
                begin
                    if (out_free)
                    begin
                        head_reg[q_reg]     <= link_rdata;
                        free_head_reg.valid <= 1'b1;
                        free_head_reg.idx   <= slot_reg;
                        m_tdata_reg         <= OUT_W'($signed(data_rdata));
                        m_tuser_reg         <= STATUS_OK;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a result only appears at the end of an operation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) != ST_IDLE))
        else $error("result raised without an operation");

    // a completed dequeue always leaves a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEQ_B && out_free) |=> free_head_reg.valid)
        else $error("free list empty after dequeue");

    // a completed enqueue leaves the queue non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENQ_C && out_free) |=> head_reg[q_reg].valid)
        else $error("queue empty after enqueue");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqsb_pkg::*;

    // idle cycles with no beat on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last result, well above the longest operation
    localparam int TAIL_CYCLES = 20;

    // one operation as offered on the slave side
    typedef struct {
        logic        mode;
        logic [2:0]  qid;
        logic [31:0] data;
        int          gap;     // idle cycles before the beat is offered
        bit          hold;    // offer only once every result has come back
    } op_beat_t;

    // one answer as seen on the master side
    typedef struct {
        logic [OUT_W-1:0]  data;
        logic [STAT_W-1:0] status;
    } answer_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    op_beat_t pending_ops[$];
    answer_t  awaited_answers[$];
    int       mismatches  = 0;
    int       idle_cycles = 0;

    // shadow copy of the queue manager
    ptr_t                  shadow_head [QUEUES];
    logic [SLOT_W-1:0]     shadow_tail [QUEUES];
    ptr_t                  shadow_link [SLOTS];
    logic [DATA_WIDTH-1:0] shadow_word [SLOTS];
    ptr_t                  shadow_free;

    multi_queue_shared_buffer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // state after reset: queues empty, every slot chained in order on the free list
    function automatic void shadow_clear();
        for (int q = 0; q < QUEUES; q++)
        begin
            shadow_head[q] = '0;
            shadow_tail[q] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_link[i].idx   = SLOT_W'(i + 1);
            shadow_link[i].valid = (i + 1 < SLOTS);
            shadow_word[i]       = '0;
        end
        shadow_free.idx   = '0;
        shadow_free.valid = 1'b1;
    endfunction

    // applies one operation to the shadow state and returns the answer it owes
    function automatic answer_t buffer_apply(input logic mode, input logic [2:0] qid,
                                             input logic [31:0] din);
        answer_t           ans;
        logic              qok;
        int                q;
        logic [SLOT_W-1:0] s;
        ptr_t              p;
        ans.data   = '1;
        ans.status = STATUS_OK;
        qok = (qid >= 1) && (qid <= QUEUES);
        q   = qok ? int'(qid) - 1 : 0;
        if (mode == MODE_ENQ)
        begin
            if (!qok || !shadow_free.valid)
                ans.status = STATUS_FULL;
            else
            begin
                s           = shadow_free.idx;
                shadow_free = shadow_link[s];
                p.valid     = 1'b1;
                p.idx       = s;
                // append behind the tail, or start the chain when the queue is empty
                if (shadow_head[q].valid)
                    shadow_link[shadow_tail[q]] = p;
                else
                    shadow_head[q] = p;
                shadow_link[s] = '0;
                shadow_tail[q] = s;
                shadow_word[s] = din[DATA_WIDTH-1:0];
            end
        end
        else
        begin
            if (!qok || !shadow_head[q].valid)
                ans.status = STATUS_EMPTY;
            else
            begin
                s              = shadow_head[q].idx;
                shadow_head[q] = shadow_link[s];
                // freed slot goes to the front of the free list
                shadow_link[s]    = shadow_free;
                shadow_free.idx   = s;
                shadow_free.valid = 1'b1;
                ans.data = OUT_W'($signed(shadow_word[s]));
            end
        end
        return ans;
    endfunction

    function automatic void add_op(input logic mode, input logic [2:0] qid,
                                   input logic [31:0] data, input int gap, input bit hold);
        op_beat_t b;
        b.mode = mode;
        b.qid  = qid;
        b.data = data;
        b.gap  = gap;
        b.hold = hold;
        pending_ops.push_back(b);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // driver: one beat at a time from the pending list, idle gap drawn per beat
    int tx_wait = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic     nxt_valid;
        op_beat_t b;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_wait = 0;
        end
        else
        begin
            nxt_valid = s_tvalid;
            // beat taken: the shadow moves on and the answer is owed
            if (s_tvalid && s_tready)
            begin
                awaited_answers.push_back(buffer_apply(s_tuser[0], s_tuser[3:1], s_tdata));
                nxt_valid = 1'b0;
                tx_wait = 0;
            end
            if (!nxt_valid && pending_ops.size() != 0)
            begin
                if (pending_ops[0].hold && awaited_answers.size() != 0)
                    ;   // hold off until the block has answered everything
                else if (tx_wait < pending_ops[0].gap)
                    tx_wait++;
                else
                begin
                    b = pending_ops.pop_front();
                    s_tdata <= b.data;
                    s_tuser <= {b.qid, b.mode};
                    nxt_valid = 1'b1;
                    tx_wait = 0;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // monitor: random back-pressure per answer, calm stretches now and then
    int rx_wait  = 0;
    int rx_stall = 0;
    int rx_count = 0;
    bit rx_calm  = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        logic    nxt_ready;
        answer_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
            rx_stall = 0;
        end
        else
        begin
            nxt_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: data_out %h status %0d", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (m_tdata !== want.data || m_tuser !== want.status)
                    begin
                        if (mismatches < 10)
                            $display("answer %0d: data_out %h status %0d, wanted %h status %0d",
                                     rx_count, m_tdata, m_tuser, want.data, want.status);
                        mismatches++;
                    end
                end
                rx_count++;
                if (rx_count % 64 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                rx_stall = rx_calm ? 0 : $urandom_range(0, 4);
                rx_wait = 0;
                nxt_ready = 1'b0;
            end
            if (!nxt_ready)
            begin
                if (rx_wait >= rx_stall)
                    nxt_ready = 1'b1;
                else
                    rx_wait++;
            end
            m_tready <= nxt_ready;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("multi_queue_shared_buffer_top: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int p_enq;
        int focus_q;
        bit idle_on;
        logic [2:0] qid;
        int r;

        shadow_clear();

        // directed part: empty queue, out of range ids, word extremes, filling the store
        add_op(MODE_DEQ, 3'd1, 32'h1234_5678, $urandom_range(0, 4), 1'b0);
        add_op(MODE_ENQ, 3'd0, 32'h0bad_0bad, $urandom_range(0, 4), 1'b0);
        add_op(MODE_DEQ, 3'd7, 32'h0, $urandom_range(0, 4), 1'b0);
        add_op(MODE_ENQ, 3'd1, 32'h8000_0000, $urandom_range(0, 4), 1'b0);
        add_op(MODE_ENQ, 3'd2, 32'h7fff_ffff, $urandom_range(0, 4), 1'b0);
        add_op(MODE_ENQ, 3'd3, 32'h0000_0000, $urandom_range(0, 4), 1'b0);
        add_op(MODE_ENQ, 3'd4, 32'hffff_ffff, $urandom_range(0, 4), 1'b0);
        for (int i = 0; i < SLOTS - 4; i++)
            add_op(MODE_ENQ, 3'($urandom_range(1, QUEUES)), $urandom, 0, 1'b0);
        // store now full
        add_op(MODE_ENQ, 3'd2, 32'hdead_beef, $urandom_range(0, 4), 1'b0);
        for (int q = 1; q <= QUEUES; q++)
            add_op(MODE_DEQ, 3'(q), $urandom, $urandom_range(0, 4), 1'b0);

        // random part in segments that lean towards filling, draining or neither
        for (int seg = 0; seg < 13; seg++)
        begin
            case ($urandom_range(0, 2))
                0: p_enq = 85;
                1: p_enq = 50;
                default: p_enq = 15;
            endcase
            focus_q = ($urandom_range(0, 1) == 0) ? $urandom_range(1, QUEUES) : 0;
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 40; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    qid = 3'($urandom_range(4, 7));
                    if (qid == 3'd4)
                        qid = 3'd0;
                end
                else if (focus_q != 0 && r < 14)
                    qid = 3'(focus_q);
                else
                    qid = 3'($urandom_range(1, QUEUES));
                add_op(($urandom_range(0, 99) < p_enq) ? MODE_ENQ : MODE_DEQ, qid, pick_word(),
                       idle_on ? $urandom_range(0, 4) : 0, (i == 0) && (seg % 4 == 0));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_answers.size() == 0)
            $display("multi_queue_shared_buffer_top: match");
        else
            $display("multi_queue_shared_buffer_top: mismatch");
        $finish;
    end

endmodule
